>>> rtl/core/ppvm_pkg.sv
package ppvm_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int BLOCK_LENGTH      = 10;

   localparam int TS_W       = 32;
   localparam int SCALE_W    = 16;
   localparam int BOUND_W    = 8;
   localparam int TENTHS_W   = 12;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SCALE_W-1:0]  PULSE_SCALE_RST  = 16'd15000;
   localparam logic [BOUND_W-1:0]  ACCEPT_LOW_RST   = 8'd8;
   localparam logic [BOUND_W-1:0]  ACCEPT_HIGH_RST  = 8'd18;
   localparam logic [TENTHS_W-1:0] ALERT_TENTHS_RST = 12'd103;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_SCALE  = 8'd0,
      CSR_ACCEPT_LOW   = 8'd1,
      CSR_ACCEPT_HIGH  = 8'd2,
      CSR_ALERT_TENTHS = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [TS_W-1:0] timestamp_ms;
      logic            pulse_high;
   } req_type;

   typedef struct packed {
      logic                sample_accepted;
      logic                average_ready;
      logic [TENTHS_W-1:0] level_tenths;
      logic                level_reportable;
      logic                low_alert;
   } rsp_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  pulse_scale;
      logic [BOUND_W-1:0]  accept_low;
      logic [BOUND_W-1:0]  accept_high;
      logic [TENTHS_W-1:0] alert_tenths;
   } csr_type;

   typedef struct packed {
      logic            accepted;
      logic [TS_W-1:0] delta;
   } job_type;

   // whole units to tenths: 8x + 2x
   function automatic logic [TENTHS_W-1:0] tenths_of(input logic [BOUND_W-1:0] bound);
      logic [TENTHS_W-1:0] wide;
      wide = TENTHS_W'(bound);
      return (wide << 3) + (wide << 1);
   endfunction

endpackage

>>> rtl/core/ppvm_front.sv
module ppvm_front
   import ppvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  csr_type csr,
   input  logic    q_full,
   output logic    push,
   output job_type push_job
);

   localparam int PROD_W = TS_W + BOUND_W;

   logic [TS_W-1:0]   last_ff, last_in;
   logic              hold_valid_ff, hold_valid_in;
   logic              hold_rising_ff, hold_rising_in;
   logic [TS_W-1:0]   hold_delta_ff, hold_delta_in;
   logic [PROD_W-1:0] low_prod, high_prod, scale_wide;
   logic              take, window_ok;

   assign req_stall = hold_valid_ff & q_full;
   assign take      = req_valid & ~req_stall;
   assign push      = hold_valid_ff & ~q_full;

   assign low_prod   = PROD_W'(csr.accept_low) * PROD_W'(hold_delta_ff);
   assign high_prod  = PROD_W'(csr.accept_high) * PROD_W'(hold_delta_ff);
   assign scale_wide = PROD_W'(csr.pulse_scale);
   assign window_ok  = (low_prod < scale_wide) && (scale_wide < high_prod);

   assign push_job.accepted = hold_rising_ff & window_ok;
   assign push_job.delta    = hold_delta_ff;

   always_comb begin
      last_in        = last_ff;
      hold_valid_in  = hold_valid_ff & ~push;
      hold_rising_in = hold_rising_ff;
      hold_delta_in  = hold_delta_ff;
      if (take) begin
         hold_valid_in  = 1'b1;
         hold_rising_in = req_data.pulse_high;
         hold_delta_in  = req_data.timestamp_ms - last_ff;
         if (req_data.pulse_high) begin
            last_in = req_data.timestamp_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         last_ff       <= last_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_rising_ff <= hold_rising_in;
      hold_delta_ff  <= hold_delta_in;
   end

endmodule

>>> rtl/core/ppvm_queue.sv
module ppvm_queue
   import ppvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   assign full  = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign empty = (occ_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      occ_in = occ_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (pop && !push) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         occ_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/ppvm_divider.sv
module ppvm_divider
   import ppvm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SCALE_W-1:0]           scale,
   input  logic [TS_W-1:0]              delta,
   output logic                         done,
   output logic [FRACTION_BITS+BOUND_W-1:0] quotient
);

   localparam int NUM_W  = SCALE_W + FRACTION_BITS;
   localparam int Q_W    = FRACTION_BITS + BOUND_W;
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [TS_W-1:0]   rem_ff, rem_in;
   logic [TS_W-1:0]   den_ff, den_in;
   logic [TS_W:0]     shifted, den_wide;
   logic              ge;

   assign shifted  = {rem_ff, num_ff[NUM_W-1]};
   assign den_wide = {1'b0, den_ff};
   assign ge       = (shifted >= den_wide);
   assign done     = done_ff;
   assign quotient = quo_ff[Q_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         num_in  = {scale, {FRACTION_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = delta;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? TS_W'(shifted - den_wide) : shifted[TS_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

>>> rtl/core/ppvm_back.sv
module ppvm_back
   import ppvm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    q_empty,
   input  job_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int Q_W   = FRACTION_BITS + BOUND_W;
   localparam int SUM_W = FRACTION_BITS + TENTHS_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_new;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, cnt_new;
   logic [TENTHS_W-1:0] level;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                out_free, div_start, div_done;
   logic [Q_W-1:0]      div_quotient;

   ppvm_divider #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .scale    (csr.pulse_scale),
      .delta    (q_head.delta),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign sum_new   = sum_ff + SUM_W'(div_quotient);
   assign cnt_new   = cnt_ff + 1'b1;
   assign level     = sum_new[FRACTION_BITS +: TENTHS_W];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               res_in = '0;
               if (q_head.accepted) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.sample_accepted = 1'b1;
               if (cnt_new == CNT_W'(BLOCK_LENGTH)) begin
                  res_in.average_ready    = 1'b1;
                  res_in.level_tenths     = level;
                  res_in.level_reportable = (level > tenths_of(csr.accept_low)) &&
                                            (level < tenths_of(csr.accept_high));
                  res_in.low_alert        = (level < csr.alert_tenths);
                  sum_in = '0;
                  cnt_in = '0;
               end else begin
                  sum_in = sum_new;
                  cnt_in = cnt_new;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/core/pulse_period_voltage_monitor_top.sv
// Pulse period voltage monitor. Each transfer on req_ is a pin event with a
// millisecond timestamp; every event yields exactly one transfer on rsp_, in
// order. A rising event measures the wrapped interval to the previous rising
// event, tests the pulse value pulse_scale/interval against the open window
// (accept_low, accept_high), and for an accepted value runs a restoring
// divider that produces one quotient bit per cycle; rejected and falling
// events skip the divider. A two-entry queue between the window check and
// the divider lets new events be taken while a division runs or a result
// waits on rsp_stall. Every tenth accepted value reports the block sum as a
// level in tenths. The user must see that registers are written through
// csr_ (always ready) only while the block is idle; the block does not
// enforce this.
module pulse_period_voltage_monitor_top
   import ppvm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type csr_ff, csr_in;
   logic    q_full, q_empty, q_pop, push;
   job_type push_job, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PULSE_SCALE:  csr_in.pulse_scale  = csr_wdata[SCALE_W-1:0];
            CSR_ACCEPT_LOW:   csr_in.accept_low   = csr_wdata[BOUND_W-1:0];
            CSR_ACCEPT_HIGH:  csr_in.accept_high  = csr_wdata[BOUND_W-1:0];
            CSR_ALERT_TENTHS: csr_in.alert_tenths = csr_wdata[TENTHS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pulse_scale  <= PULSE_SCALE_RST;
         csr_ff.accept_low   <= ACCEPT_LOW_RST;
         csr_ff.accept_high  <= ACCEPT_HIGH_RST;
         csr_ff.alert_tenths <= ALERT_TENTHS_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ppvm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr       (csr_ff),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   ppvm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   ppvm_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/ppvm_checker.sv
module ppvm_checker
   import ppvm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_level_only_on_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.average_ready |->
         rsp_data.level_tenths == '0 && !rsp_data.level_reportable && !rsp_data.low_alert)
      else $error("level flags without a completed block");

   a_ready_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.average_ready |-> rsp_data.sample_accepted)
      else $error("block completed on a rejected sample");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

endmodule

bind pulse_period_voltage_monitor_top ppvm_checker u_ppvm_checker (.*);
